// ===== sv/scba_pkg.sv =====
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, status codes and constants for the size-class allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

    localparam int OFF_W       = 58;
    localparam int SIZE_W      = 40;
    localparam int TOTAL_W     = 64;
    localparam int CLASS_W     = 5;
    localparam int SLOTS       = 64;
    localparam int SLOT_W      = 6;
    localparam int MIN_SHIFT   = 6;
    localparam int TOP_CLASS   = 31;
    localparam int MAX_BLOCKS_DEF = 64;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_BIG   = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_UNALIGNED = 3'd3,
        ST_NOT_ALLOC = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN,
        CMD_OPEN,
        CMD_GRANT,
        CMD_RELEASE,
        CMD_ERROR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        status_t err;
    } cmd_t;

    typedef struct packed {
        logic too_big;
        logic scan_done;
        logic hit;
        logic table_full;
        logic heap_full;
        logic unaligned;
        logic double_free;
        logic is_free;
    } sts_t;

endpackage

// ===== sv/size_class_bitmap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator_core
// Power-of-two size-class allocator over 64-slot blocks with a block table.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  mode, req_size, free_offset
//   out      source     out_valid/out_stall  alloc_offset, status,
//                                            total_allocated_bytes
//
// The result waits on the serial scan over the block table, one entry a
// cycle; a too-big request skips the scan. The next transfer is accepted
// in the cycle after the result transfer.
// Reset clears the table count, heap pointer and total; no clearing pass.
// The input is stalled from acceptance until the result transfer completes.
// ----------------------------------------------------------------------------
module size_class_bitmap_allocator_core
#(
    parameter int MAX_BLOCKS = scba_pkg::MAX_BLOCKS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [scba_pkg::SIZE_W-1:0]   req_size,
    input  logic [scba_pkg::OFF_W-1:0]    free_offset,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scba_pkg::OFF_W-1:0]    alloc_offset,
    output logic [2:0]                    status,
    output logic [scba_pkg::TOTAL_W-1:0]  total_allocated_bytes
);
    import scba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    scba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    scba_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .mode                  (mode),
        .req_size              (req_size),
        .free_offset           (free_offset),
        .cmd                   (cmd),
        .sts                   (sts),
        .alloc_offset          (alloc_offset),
        .status                (status),
        .total_allocated_bytes (total_allocated_bytes)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    a_offset_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (alloc_offset == '0))
        else $error("nonzero offset on error");

    a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && $past(out_valid)) |-> $stable(total_allocated_bytes))
        else $error("total changed while result pending");

endmodule

// ===== sv/scba_ctrl.sv =====
// ----------------------------------------------------------------------------
// scba_ctrl
// Request sequencer: load, table scan, open/grant or release, respond.
// ----------------------------------------------------------------------------
module scba_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output scba_pkg::cmd_t cmd,
    input  scba_pkg::sts_t sts
);
    import scba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = CMD_NONE;
        cmd.err        = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.is_free && sts.too_big)
                begin
                    cmd.op     = CMD_ERROR;
                    cmd.err    = ST_TOO_BIG;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = CMD_SCAN;
                if (sts.hit || sts.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // advance to update; the data path has latched the hit entry
                state_next = S_UPDATE;
                if (sts.is_free)
                begin
                    if (!sts.hit)
                    begin
                        cmd.op     = CMD_ERROR;
                        cmd.err    = ST_NOT_ALLOC;
                        state_next = S_RESP;
                    end
                end
                else if (!sts.hit && (sts.table_full || sts.heap_full))
                begin
                    cmd.op     = CMD_ERROR;
                    cmd.err    = ST_NO_SPACE;
                    state_next = S_RESP;
                end
                else if (!sts.hit)
                begin
                    cmd.op = CMD_OPEN;
                end
            end
            S_UPDATE:
            begin
                state_next = S_RESP;
                if (sts.is_free)
                begin
                    if (sts.unaligned)
                    begin
                        cmd.op  = CMD_ERROR;
                        cmd.err = ST_UNALIGNED;
                    end
                    else if (sts.double_free)
                    begin
                        cmd.op  = CMD_ERROR;
                        cmd.err = ST_NOT_ALLOC;
                    end
                    else
                    begin
                        cmd.op = CMD_RELEASE;
                    end
                end
                else
                begin
                    cmd.op = CMD_GRANT;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                end
                else if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/scba_dp.sv =====
// ----------------------------------------------------------------------------
// scba_dp
// Block table, heap pointer, running total and result registers.
// ----------------------------------------------------------------------------
module scba_dp
#(
    parameter int MAX_BLOCKS = scba_pkg::MAX_BLOCKS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          mode,
    input  logic [scba_pkg::SIZE_W-1:0]   req_size,
    input  logic [scba_pkg::OFF_W-1:0]    free_offset,
    input  scba_pkg::cmd_t                cmd,
    output scba_pkg::sts_t                sts,
    output logic [scba_pkg::OFF_W-1:0]    alloc_offset,
    output logic [2:0]                    status,
    output logic [scba_pkg::TOTAL_W-1:0]  total_allocated_bytes
);
    import scba_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [OFF_W-1:0]   base_mem  [MAX_BLOCKS];
    logic [CLASS_W-1:0] class_mem [MAX_BLOCKS];
    logic [SLOTS-1:0]   map_mem   [MAX_BLOCKS];

    logic               mode_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [OFF_W-1:0]   addr_reg;
    logic [5:0]         cls_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   scan_reg;
    logic [OFF_W-1:0]   heap_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [OFF_W-1:0]   e_base_reg;
    logic [CLASS_W-1:0] e_class_reg;
    logic [SLOTS-1:0]   e_map_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [2:0]         status_reg;

    // class of the request: smallest g with 2^(g+6) >= size
    logic [5:0]         cls_next;
    always_comb
    begin
        cls_next = 6'd34;
        for (int g = 33; g >= 0; g--)
        begin
            if ((SIZE_W'(1) << (g + MIN_SHIFT)) >= size_reg)
            begin
                cls_next = 6'(g);
            end
        end
    end

    // scan entry read registers
    logic [IDX_W-1:0]   rd_idx;
    logic [OFF_W-1:0]   rd_base;
    logic [CLASS_W-1:0] rd_class;
    logic [SLOTS-1:0]   rd_map;
    logic               rd_valid_reg;
    logic [CNT_W-1:0]   rd_pos_reg;

    assign rd_idx = scan_reg[IDX_W-1:0];

    // hit test on registered read
    logic [OFF_W+7:0]   r_span;
    logic [OFF_W:0]     r_diff;
    logic               r_hit;
    always_comb
    begin
        r_span = (OFF_W+8)'(1) << (rd_class + CLASS_W'(MIN_SHIFT) + 6'd6);
        r_diff = {1'b0, addr_reg} - {1'b0, rd_base};
        if (mode_reg)
        begin
            r_hit = !r_diff[OFF_W] && ((OFF_W+8)'(r_diff) < r_span);
        end
        else
        begin
            r_hit = (rd_class == cls_reg[CLASS_W-1:0]) && (rd_map != '0);
        end
    end

    // new block placement
    logic [OFF_W+7:0] n_span;
    logic [OFF_W+7:0] n_base;
    logic             heap_full;
    assign n_span = (OFF_W+8)'(1) << (cls_reg + 6'd12);
    assign n_base = ({8'd0, heap_reg} + n_span - 1'b1) & ~(n_span - 1'b1);
    assign heap_full = (n_base + n_span) >= ((OFF_W+8)'(1) << OFF_W);

    // entry arithmetic for the latched entry
    logic [5:0]       e_shift;
    logic [5:0]       low_slot;
    logic [OFF_W-1:0] frag_mask;
    logic [OFF_W-1:0] rel;
    logic [5:0]       rel_slot;
    always_comb
    begin
        e_shift  = {1'b0, e_class_reg} + 6'(MIN_SHIFT);
        low_slot = 6'd63;
        for (int i = 63; i >= 0; i--)
        begin
            if (e_map_reg[i])
            begin
                low_slot = 6'(i);
            end
        end
        frag_mask = (OFF_W'(1) << e_shift) - 1'b1;
        rel       = addr_reg - e_base_reg;
        rel_slot  = 6'(rel >> e_shift);
    end

    always_comb
    begin
        sts.is_free     = mode_reg;
        sts.too_big     = (cls_next > 6'(TOP_CLASS));
        sts.hit         = hit_reg;
        sts.scan_done   = (scan_reg >= used_reg) && !rd_valid_reg;
        sts.table_full  = (used_reg >= CNT_W'(MAX_BLOCKS));
        sts.heap_full   = heap_full;
        sts.unaligned   = (addr_reg & frag_mask) != '0;
        sts.double_free = e_map_reg[rel_slot];
    end

    always_ff @(posedge clk)
    begin
        rd_base  <= base_mem[rd_idx];
        rd_class <= class_mem[rd_idx];
        rd_map   <= map_mem[rd_idx];
        if (cmd.op == CMD_OPEN)
        begin
            base_mem[used_reg[IDX_W-1:0]]  <= n_base[OFF_W-1:0];
            class_mem[used_reg[IDX_W-1:0]] <= cls_reg[CLASS_W-1:0];
            map_mem[used_reg[IDX_W-1:0]]   <= '1;
        end
        else if (cmd.op == CMD_GRANT)
        begin
            map_mem[idx_reg] <= e_map_reg & ~(SLOTS'(1) << low_slot);
        end
        else if (cmd.op == CMD_RELEASE)
        begin
            map_mem[idx_reg] <= e_map_reg | (SLOTS'(1) << rel_slot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LOAD)
        begin
            mode_reg <= mode;
            size_reg <= req_size;
            addr_reg <= free_offset;
        end
        if (cmd.op == CMD_OPEN)
        begin
            idx_reg     <= used_reg[IDX_W-1:0];
            e_base_reg  <= n_base[OFF_W-1:0];
            e_class_reg <= cls_reg[CLASS_W-1:0];
            e_map_reg   <= '1;
        end
        else if (cmd.op == CMD_SCAN && rd_valid_reg && r_hit && !hit_reg)
        begin
            idx_reg     <= rd_pos_reg[IDX_W-1:0];
            e_base_reg  <= rd_base;
            e_class_reg <= rd_class;
            e_map_reg   <= rd_map;
        end
        if (cmd.op == CMD_GRANT)
        begin
            off_reg <= e_base_reg + (OFF_W'(low_slot) << e_shift);
        end
        else
        begin
            if (cmd.op == CMD_LOAD || cmd.op == CMD_ERROR || cmd.op == CMD_RELEASE)
            begin
                off_reg <= '0;
            end
        end
        if (cmd.op == CMD_ERROR)
        begin
            status_reg <= cmd.err;
        end
        else if (cmd.op == CMD_GRANT || cmd.op == CMD_RELEASE)
        begin
            status_reg <= ST_OK;
        end
        cls_reg <= (cmd.op == CMD_LOAD) ? 6'd0 : cls_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            heap_reg     <= '0;
            total_reg    <= '0;
            scan_reg     <= '0;
            hit_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_pos_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                CMD_LOAD:
                begin
                    scan_reg     <= '0;
                    hit_reg      <= 1'b0;
                    rd_valid_reg <= 1'b0;
                end
                CMD_SCAN:
                begin
                    rd_valid_reg <= (scan_reg < used_reg);
                    rd_pos_reg   <= scan_reg;
                    if (scan_reg < used_reg)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    if (rd_valid_reg && r_hit)
                    begin
                        hit_reg <= 1'b1;
                    end
                end
                CMD_OPEN:
                begin
                    used_reg <= used_reg + 1'b1;
                    heap_reg <= OFF_W'(n_base + n_span);
                end
                CMD_GRANT:
                begin
                    total_reg <= total_reg + (TOTAL_W'(1) << e_shift);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign alloc_offset          = off_reg;
    assign status                = status_reg;
    assign total_allocated_bytes = total_reg;

endmodule

// ===== dv/scba_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scba_checker
// Watches both channels of the size-class allocator, keeps its own copy of
// the block table, heap pointer and byte total, works out the result of each
// accepted request and compares it field by field with the returned transfer.
// ----------------------------------------------------------------------------
module scba_checker
#(
    parameter int MAX_BLOCKS = scba_pkg::MAX_BLOCKS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          mode,
    input  logic [scba_pkg::SIZE_W-1:0]   req_size,
    input  logic [scba_pkg::OFF_W-1:0]    free_offset,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [scba_pkg::OFF_W-1:0]    alloc_offset,
    input  logic [2:0]                    status,
    input  logic [scba_pkg::TOTAL_W-1:0]  total_allocated_bytes,
    output int                            errors,
    output int                            pending
);
    import scba_pkg::*;

    typedef struct {
        logic [OFF_W-1:0]   offset;
        status_t            st;
        logic [TOTAL_W-1:0] total;
    } grant_t;

    logic [OFF_W-1:0]   blk_base [MAX_BLOCKS];
    logic [CLASS_W-1:0] blk_class [MAX_BLOCKS];
    bit                 blk_full [MAX_BLOCKS];
    logic [63:0]        blk_map [MAX_BLOCKS];
    int                 blk_used;
    logic [63:0]        heap_ptr;
    logic [TOTAL_W-1:0] byte_total;
    grant_t             grants_q[$];

    function automatic grant_t alloc_predict(input logic [SIZE_W-1:0] n);
        grant_t g;
        int cls;
        int idx;
        int slot;
        logic [63:0] frag;
        logic [63:0] span;
        logic [63:0] base;
        g.offset = '0;
        g.total = byte_total;
        cls = 0;
        while (cls < 40 && (64'd1 << (cls + MIN_SHIFT)) < {24'd0, n})
            cls++;
        if (cls > TOP_CLASS)
        begin
            g.st = ST_TOO_BIG;
            return g;
        end
        frag = 64'd1 << (cls + MIN_SHIFT);
        span = frag * SLOTS;
        idx = -1;
        for (int i = 0; i < blk_used; i++)
            if (idx < 0 && blk_class[i] == cls && !blk_full[i] && blk_map[i] != 0)
                idx = i;
        if (idx < 0)
        begin
            base = (heap_ptr + span - 1) & ~(span - 1);
            if (blk_used >= MAX_BLOCKS || base + span >= (64'd1 << OFF_W))
            begin
                g.st = ST_NO_SPACE;
                return g;
            end
            idx = blk_used++;
            blk_base[idx] = base[OFF_W-1:0];
            blk_class[idx] = cls[CLASS_W-1:0];
            blk_full[idx] = 0;
            blk_map[idx] = '1;
            heap_ptr = base + span;
        end
        slot = 0;
        while (slot < 63 && !blk_map[idx][slot])
            slot++;
        blk_map[idx][slot] = 1'b0;
        blk_full[idx] = (blk_map[idx] == 0);
        g.offset = blk_base[idx] + OFF_W'(slot * frag);
        byte_total += frag;
        g.total = byte_total;
        g.st = ST_OK;
        return g;
    endfunction

    function automatic status_t release_predict(input logic [OFF_W-1:0] a);
        logic [63:0] frag;
        logic [63:0] delta;
        int bitpos;
        for (int i = 0; i < blk_used; i++)
        begin
            frag = 64'd1 << (blk_class[i] + MIN_SHIFT);
            delta = {6'd0, a} - {6'd0, blk_base[i]};
            if (a >= blk_base[i] && delta < frag * SLOTS)
            begin
                if (({6'd0, a} & (frag - 1)) != 0)
                    return ST_UNALIGNED;
                bitpos = int'((delta / frag) & 63);
                if (blk_map[i][bitpos])
                    return ST_NOT_ALLOC;
                blk_map[i][bitpos] = 1'b1;
                blk_full[i] = 0;
                return ST_OK;
            end
        end
        return ST_NOT_ALLOC;
    endfunction

    assign pending = grants_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        grant_t g;
        if (!rst_n)
        begin
            blk_used = 0;
            heap_ptr = '0;
            byte_total = '0;
            errors <= 0;
            grants_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (grants_q.size() == 0)
                begin
                    $display("%0t result with nothing expected: offset %h status %0d total %h",
                             $time, alloc_offset, status, total_allocated_bytes);
                    errors <= errors + 1;
                end
                else
                begin
                    g = grants_q.pop_front();
                    if (alloc_offset !== g.offset || status !== g.st
                        || total_allocated_bytes !== g.total)
                    begin
                        $display("%0t mismatch: expected offset %h status %0d total %h",
                                 $time, g.offset, g.st, g.total);
                        $display("%0t           actual   offset %h status %0d total %h",
                                 $time, alloc_offset, status, total_allocated_bytes);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (mode == 1'b0)
                    g = alloc_predict(req_size);
                else
                begin
                    g.offset = '0;
                    g.st = release_predict(free_offset);
                    g.total = byte_total;
                end
                grants_q.push_back(g);
            end
        end
    end

endmodule

// ===== dv/tb_size_class_bitmap_allocator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_size_class_bitmap_allocator_core
// Drives allocate and free requests into the size-class allocator: a directed
// opening over class edges and error cases, then random phases of mostly
// well-formed allocate/free traffic under varying sender and receiver idling,
// with one long receiver hold-off. Results are checked by scba_checker.
// ----------------------------------------------------------------------------
module tb_size_class_bitmap_allocator_core;
    import scba_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                mode;
    logic [SIZE_W-1:0]   req_size;
    logic [OFF_W-1:0]    free_offset;
    logic                out_valid;
    logic                out_stall;
    logic [OFF_W-1:0]    alloc_offset;
    logic [2:0]          status;
    logic [TOTAL_W-1:0]  total_allocated_bytes;
    int                  errors;
    int                  pending;
    int                  send_idle_pct;
    int                  stall_pct;
    int                  idle_cycles;
    logic                modes_q[$];
    logic [OFF_W-1:0]    live_q[$];
    logic [OFF_W-1:0]    freed_q[$];

    size_class_bitmap_allocator_core uut (.*);

    scba_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // receiver: random stalls, plus one long hold-off
    always @(posedge clk)
    begin
        int cyc;
        int hold;
        cyc++;
        if (cyc == 2500)
            hold = 300;
        if (hold > 0)
        begin
            hold--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // track granted offsets for later frees
    always @(posedge clk)
    begin
        logic m;
        if (out_valid && !out_stall && modes_q.size() > 0)
        begin
            m = modes_q.pop_front();
            if (m == 1'b0 && status == ST_OK)
                live_q.push_back(alloc_offset);
        end
        if (in_valid && !in_stall)
            modes_q.push_back(mode);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send(input logic m, input logic [SIZE_W-1:0] s,
                        input logic [OFF_W-1:0] o);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        mode <= m;
        req_size <= s;
        free_offset <= o;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic random_request();
        int pick;
        int k;
        logic [OFF_W-1:0] a;
        logic [SIZE_W-1:0] s;
        pick = $urandom_range(99);
        if (pick < 52)
        begin
            if ($urandom_range(9) < 7)
                s = SIZE_W'($urandom_range(0, 600));
            else
                s = (SIZE_W'(1) << $urandom_range(0, 37)) - SIZE_W'($urandom_range(0, 1))
                    + SIZE_W'($urandom_range(0, 1));
            send(1'b0, s, OFF_W'({$urandom, $urandom}));
        end
        else if (pick < 88 && live_q.size() > 0)
        begin
            k = $urandom_range(0, live_q.size() - 1);
            a = live_q[k];
            live_q.delete(k);
            freed_q.push_back(a);
            if (freed_q.size() > 16)
                void'(freed_q.pop_front());
            send(1'b1, SIZE_W'({$urandom, $urandom}), a);
        end
        else if (pick < 92 && freed_q.size() > 0)
            send(1'b1, '0, freed_q[$urandom_range(0, freed_q.size() - 1)]);
        else if (pick < 95 && live_q.size() > 0)
            send(1'b1, '0, live_q[$urandom_range(0, live_q.size() - 1)]
                 + OFF_W'($urandom_range(1, 63)));
        else if (pick < 98)
            send(1'b1, SIZE_W'({$urandom, $urandom}), OFF_W'({$urandom, $urandom}));
        else
            send(1'b0, SIZE_W'({$urandom, $urandom}), OFF_W'({$urandom, $urandom}));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = 1'b0;
        req_size = '0;
        free_offset = '0;
        out_stall = 1'b0;
        idle_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(1'b1, '0, '0);
        send(1'b1, '1, '1);
        send(1'b0, '0, '1);
        send(1'b0, 40'd1, '0);
        send(1'b0, 40'd64, '0);
        send(1'b0, 40'd65, '0);
        send(1'b0, 40'd128, '0);
        send(1'b0, 40'd1 << 37, '0);
        send(1'b0, (40'd1 << 37) + 40'd1, '0);
        send(1'b0, '1, '0);
        send(1'b1, '0, 58'd64);
        send(1'b1, '0, 58'd64);
        send(1'b1, '0, 58'd65);
        send(1'b1, '0, 58'd4096);
        send(1'b1, '0, '1);
        send(1'b0, 40'd1 << 36, '0);
        send(1'b1, '0, 58'd1 << 43);
        send(1'b1, '0, (58'd1 << 43) + 58'd1);
        send(1'b0, 40'd3000, '0);
        send(1'b0, 40'd0, '0);
        while (pending > 0)
            @(posedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 47 : 25) : 0;
            stall_pct <= (ph == 2) ? 47 : ((ph == 3) ? 25 : 0);
            for (int n = 0; n < 460; n++)
                random_request();
        end
        in_valid <= 1'b0;

        while (pending > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
